// File: rtl/ook_remote_frame_chip_generator_defines.svh
// Assertion macros shared by the checker.
`ifndef OOK_REMOTE_FRAME_CHIP_GENERATOR_DEFINES_SVH
`define OOK_REMOTE_FRAME_CHIP_GENERATOR_DEFINES_SVH

// Same-cycle implication, sampled on aclk, off during reset.
`define OOK_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on aclk, off during reset.
`define OOK_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/ook_pkg.sv
package ook_pkg;

    localparam int CODE_BITS_DEF = 24;

    localparam int CODE_W = 24;
    localparam int REP_W  = 8;
    localparam int CPP_W  = 5;
    localparam int PER_W  = 5;
    localparam int CHIP_W = 4;

    localparam logic [CPP_W-1:0] CPP_MIN = 5'd1;
    localparam logic [CPP_W-1:0] CPP_MAX = 5'd16;

    localparam logic [PER_W-1:0] SYNC_LAST = 5'd31;
    localparam logic [PER_W-1:0] BIT_LAST  = 5'd3;
    localparam logic [PER_W-1:0] ONE_ON    = 5'd3;
    localparam logic [PER_W-1:0] ZERO_ON   = 5'd1;

    localparam logic OP_START = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    localparam logic REG_CPP     = 1'b0;
    localparam logic REG_CARRIER = 1'b1;

    typedef struct packed {
        logic chip;
        logic frame_end;
        logic burst_end;
    } ook_res_t;

endpackage

// File: rtl/ook_skid.sv
module ook_skid
    import ook_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     in_valid,
    output logic     in_ready,
    input  ook_res_t in_res,
    output logic     out_valid,
    input  logic     out_ready,
    output ook_res_t out_res
);

    logic     out_valid_reg, out_valid_next;
    logic     skid_valid_reg, skid_valid_next;
    ook_res_t out_res_reg, out_res_next;
    ook_res_t skid_res_reg, skid_res_next;
    logic     out_free;

    assign in_ready  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;
    assign out_free  = out_ready || !out_valid_reg;

    always_comb begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_res_next    = out_res_reg;
        skid_res_next   = skid_res_reg;
        if (out_free) begin
            if (skid_valid_reg) begin
                out_valid_next  = 1'b1;
                out_res_next    = skid_res_reg;
                skid_valid_next = 1'b0;
            end else begin
                out_valid_next = in_valid;
                out_res_next   = in_res;
            end
        end else if (in_valid && !skid_valid_reg) begin
            skid_valid_next = 1'b1;
            skid_res_next   = in_res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_res_reg  <= out_res_next;
        skid_res_reg <= skid_res_next;
    end

endmodule

// File: rtl/ook_remote_frame_chip_generator.sv
// Channel  | Ports                              | Carries
// s_       | s_tvalid s_tready s_tdata s_tuser  | start (code, repeats) or tick
// m_       | m_tvalid m_tready m_tdata m_tlast  | one chip, frame end, burst end
// APB      | psel penable pwrite paddr pwdata   | chips_per_period, carrier_level
//
// One transaction per cycle in and out while s_tready and m_tready are high; a tick while busy gives a registered chip.
// Frame state advances in one pass from the registered counters; a two-entry output
// stage (result plus skid) keeps s_tready high while a result waits on m_tready.
// s_tready drops only when both output entries are full.
// aresetn is synchronous, active low; it clears the counters and sets both registers to 1.
module ook_remote_frame_chip_generator
    import ook_pkg::*;
#(
    parameter int CODE_BITS = CODE_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,    // code[23:0], repeats[31:24]
    input  logic [0:0]  s_tuser,    // operation
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,    // chip[0], zeros[7:1]
    output logic        m_tlast,
    output logic [0:0]  m_tuser,    // burst_end
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int SEG_W = $clog2(CODE_BITS + 1);
    localparam logic [SEG_W-1:0] SEG_LAST = SEG_W'(CODE_BITS);

    logic [CPP_W-1:0]  cpp_reg;
    logic              carrier_reg;
    logic              busy_reg, busy_next;
    logic [CODE_W-1:0] code_reg, code_next;
    logic [REP_W-1:0]  frames_reg, frames_next;
    logic [SEG_W-1:0]  seg_reg, seg_next;
    logic [PER_W-1:0]  per_reg, per_next;
    logic [CHIP_W-1:0] chip_cnt_reg, chip_cnt_next;

    logic              s_acc;
    logic              op;
    logic [CODE_W-1:0] in_code;
    logic [REP_W-1:0]  in_reps;
    logic [CPP_W-1:0]  cpp_eff;
    logic [SEG_W-1:0]  bitpos;
    logic [CODE_W-1:0] code_sh;
    logic              carrier_on;
    logic              last_chip, last_period, last_slot, fend, bend;
    logic              res_valid;
    ook_res_t          res, m_res;
    logic              cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cpp_reg     <= CPP_MIN;
            carrier_reg <= 1'b1;
        end else if (cfg_wr) begin
            case (paddr[2])
                REG_CPP:     cpp_reg     <= pwdata[CPP_W-1:0];
                REG_CARRIER: carrier_reg <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_CPP:     prdata = {{(32-CPP_W){1'b0}}, cpp_reg};
            REG_CARRIER: prdata = {31'd0, carrier_reg};
            default:     prdata = 32'd0;
        endcase
    end

    assign s_acc   = s_tvalid && s_tready;
    assign op      = s_tuser[0];
    assign in_code = s_tdata[CODE_W-1:0];
    assign in_reps = s_tdata[CODE_W+REP_W-1:CODE_W];

    assign cpp_eff = (cpp_reg == '0) ? CPP_MIN : ((cpp_reg > CPP_MAX) ? CPP_MAX : cpp_reg);

    assign bitpos  = SEG_LAST - seg_reg;
    assign code_sh = code_reg >> bitpos;

    always_comb begin
        if (seg_reg == '0) begin
            carrier_on = (per_reg == '0);
        end else begin
            carrier_on = per_reg < (code_sh[0] ? ONE_ON : ZERO_ON);
        end
    end

    assign last_chip   = ({1'b0, chip_cnt_reg} + CPP_W'(1)) >= cpp_eff;
    assign last_period = per_reg >= ((seg_reg == '0) ? SYNC_LAST : BIT_LAST);
    assign last_slot   = seg_reg >= SEG_LAST;
    assign fend        = last_chip && last_period && last_slot;
    assign bend        = fend && (frames_reg <= REP_W'(1));

    assign res_valid     = s_acc && (op == OP_TICK) && busy_reg;
    assign res.chip      = carrier_on ? carrier_reg : !carrier_reg;
    assign res.frame_end = fend;
    assign res.burst_end = bend;

    always_comb begin
        busy_next     = busy_reg;
        code_next     = code_reg;
        frames_next   = frames_reg;
        seg_next      = seg_reg;
        per_next      = per_reg;
        chip_cnt_next = chip_cnt_reg;
        if (s_acc && (op == OP_START)) begin
            if (!busy_reg && (in_reps != '0)) begin
                busy_next     = 1'b1;
                code_next     = in_code;
                frames_next   = in_reps;
                seg_next      = '0;
                per_next      = '0;
                chip_cnt_next = '0;
            end
        end else if (res_valid) begin
            if (!last_chip) begin
                chip_cnt_next = chip_cnt_reg + CHIP_W'(1);
            end else begin
                chip_cnt_next = '0;
                if (!last_period) begin
                    per_next = per_reg + PER_W'(1);
                end else begin
                    per_next = '0;
                    if (!last_slot) begin
                        seg_next = seg_reg + SEG_W'(1);
                    end else begin
                        seg_next    = '0;
                        frames_next = frames_reg - REP_W'(1);
                        if (bend) begin
                            busy_next   = 1'b0;
                            frames_next = '0;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg     <= 1'b0;
            code_reg     <= '0;
            frames_reg   <= '0;
            seg_reg      <= '0;
            per_reg      <= '0;
            chip_cnt_reg <= '0;
        end else begin
            busy_reg     <= busy_next;
            code_reg     <= code_next;
            frames_reg   <= frames_next;
            seg_reg      <= seg_next;
            per_reg      <= per_next;
            chip_cnt_reg <= chip_cnt_next;
        end
    end

    ook_skid u_skid (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (res_valid),
        .in_ready  (s_tready),
        .in_res    (res),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (m_res)
    );

    assign m_tdata = {7'd0, m_res.chip};
    assign m_tlast = m_res.frame_end;
    assign m_tuser = m_res.burst_end;

endmodule

// File: rtl/ook_chk.sv
`include "ook_remote_frame_chip_generator_defines.svh"

module ook_chk (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [7:0]  m_tdata,
    input logic        m_tlast,
    input logic [0:0]  m_tuser,
    input logic        psel,
    input logic        penable,
    input logic        pwrite,
    input logic [2:0]  paddr,
    input logic [31:0] pwdata,
    input logic [31:0] prdata
);

    `OOK_ASSERT_NOW(a_burst_ends_frame, m_tvalid && m_tuser[0], m_tlast, "burst end without frame end")

    `OOK_ASSERT_NOW(a_chip_pad_zero, m_tvalid, m_tdata[7:1] == 7'd0, "nonzero pad bits in m_tdata")

    `OOK_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser), "output changed while stalled")

    `OOK_ASSERT_NEXT(a_carrier_readback, psel && penable && pwrite && paddr[2], (psel && !pwrite && paddr[2]) ? (prdata[0] == $past(pwdata[0])) : 1'b1, "carrier_level readback mismatch")

endmodule

bind ook_remote_frame_chip_generator ook_chk u_ook_chk (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata)
);

// File: test/ook_chip_checker.sv
`timescale 1ns / 1ps

module ook_chip_checker
    import ook_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [31:0] s_tdata,    // code[23:0], repeats[31:24]
    input  logic [0:0]  s_tuser,    // operation
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [7:0]  m_tdata,    // chip[0], zeros[7:1]
    input  logic        m_tlast,
    input  logic [0:0]  m_tuser,    // burst_end
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic        pready,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output int          mismatches,
    output int          chips_pending,
    output logic        burst_busy
);

    ook_res_t chips_due[$];

    logic [CPP_W-1:0]  cpp_reg;
    logic              carrier_reg;
    logic              busy;
    logic [CODE_W-1:0] code_word;
    logic [REP_W-1:0]  frames_left;
    logic [5:0]        slot;
    logic [PER_W-1:0]  period;
    logic [CHIP_W-1:0] chip_cnt;

    always @(posedge aclk) begin
        int          cpp_eff;
        logic        on;
        logic        bit_val;
        logic        last_chip;
        logic        last_period;
        logic        last_slot;
        ook_res_t    want;
        if (!aresetn) begin
            cpp_reg = CPP_MIN;
            carrier_reg = 1'b1;
            busy = 1'b0;
            code_word = '0;
            frames_left = '0;
            slot = '0;
            period = '0;
            chip_cnt = '0;
            mismatches = 0;
            chips_due.delete();
        end else begin
            if (s_tvalid && s_tready) begin
                if (s_tuser[0] == OP_START) begin
                    if (!busy && s_tdata[31:24] != '0) begin
                        busy = 1'b1;
                        code_word = s_tdata[23:0];
                        frames_left = s_tdata[31:24];
                        slot = '0;
                        period = '0;
                        chip_cnt = '0;
                    end
                end else if (busy) begin
                    if (cpp_reg == '0) begin
                        cpp_eff = 1;
                    end else if (cpp_reg > CPP_MAX) begin
                        cpp_eff = int'(CPP_MAX);
                    end else begin
                        cpp_eff = int'(cpp_reg);
                    end

                    if (slot == '0) begin
                        on = (period == '0);
                    end else begin
                        bit_val = code_word[CODE_BITS_DEF - int'(slot)];
                        on = period < (bit_val ? ONE_ON : ZERO_ON);
                    end

                    last_chip = (int'(chip_cnt) + 1) >= cpp_eff;
                    last_period = period >= ((slot == '0) ? SYNC_LAST : BIT_LAST);
                    last_slot = int'(slot) >= CODE_BITS_DEF;

                    want.chip = on ? carrier_reg : ~carrier_reg;
                    want.frame_end = last_chip && last_period && last_slot;
                    want.burst_end = want.frame_end && (frames_left <= REP_W'(1));
                    chips_due.push_back(want);

                    if (!last_chip) begin
                        chip_cnt = chip_cnt + CHIP_W'(1);
                    end else begin
                        chip_cnt = '0;
                        if (!last_period) begin
                            period = period + PER_W'(1);
                        end else begin
                            period = '0;
                            if (!last_slot) begin
                                slot = slot + 6'd1;
                            end else begin
                                slot = '0;
                                frames_left = frames_left - REP_W'(1);
                                if (want.burst_end) begin
                                    busy = 1'b0;
                                    frames_left = '0;
                                end
                            end
                        end
                    end
                end
            end

            if (psel && penable && pwrite && pready) begin
                if (paddr[2] == REG_CPP) begin
                    cpp_reg = pwdata[CPP_W-1:0];
                end else begin
                    carrier_reg = pwdata[0];
                end
            end

            if (m_tvalid && m_tready) begin
                if (chips_due.size() == 0) begin
                    $error("result transaction with no chip pending");
                    mismatches++;
                end else begin
                    want = chips_due.pop_front();
                    if (m_tdata[0] !== want.chip) begin
                        $error("chip: expected %0d, got %0d", want.chip, m_tdata[0]);
                        mismatches++;
                    end
                    if (m_tlast !== want.frame_end) begin
                        $error("frame_end: expected %0d, got %0d", want.frame_end, m_tlast);
                        mismatches++;
                    end
                    if (m_tuser[0] !== want.burst_end) begin
                        $error("burst_end: expected %0d, got %0d", want.burst_end,
                               m_tuser[0]);
                        mismatches++;
                    end
                end
            end
        end
        chips_pending <= chips_due.size();
        burst_busy <= busy;
    end

endmodule

// File: test/tb_ook_remote_frame_chip_generator.sv
`timescale 1ns / 1ps

module tb_ook_remote_frame_chip_generator;
    import ook_pkg::*;

    typedef enum {IDLE_SENDER_LIGHT, IDLE_SENDER_HEAVY, IDLE_NONE} idle_mode_t;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASES = 8;
    localparam int ITEMS_PER_PHASE = 36;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic [0:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic        m_tlast;
    logic [0:0]  m_tuser;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    int   mismatches;
    int   chips_pending;
    logic burst_busy;

    int   gap_pct = 0;
    int   stall_pct = 0;
    int   quiet_cycles = 0;
    logic prev_op = OP_TICK;

    int cpp_plan [PHASES] = '{1, 0, 2, 16, 31, 3, 1, 4};
    logic carrier_plan [PHASES] = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0};

    ook_remote_frame_chip_generator dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    ook_chip_checker checker_i (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tlast       (m_tlast),
        .m_tuser       (m_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .pready        (pready),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .mismatches    (mismatches),
        .chips_pending (chips_pending),
        .burst_busy    (burst_busy)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        m_tready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic set_idle(input idle_mode_t mode);
        case (mode)
            IDLE_SENDER_LIGHT: begin
                gap_pct = 20;
                stall_pct = 46;
            end
            IDLE_SENDER_HEAVY: begin
                gap_pct = 46;
                stall_pct = 20;
            end
            default: begin
                gap_pct = 0;
                stall_pct = 0;
            end
        endcase
    endtask

    task automatic apb_write(input logic reg_sel, input logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {reg_sel, 2'b00};
        pwdata <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic send_item(input logic op, input logic [23:0] code,
                             input logic [7:0] reps);
        while ($urandom_range(99) < gap_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= {reps, code};
        do @(posedge aclk); while (!s_tready);
        prev_op = op;
    endtask

    // Hold off until all chips are back.
    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (chips_pending != 0);
        repeat (4) @(posedge aclk);
    endtask

    // Tick out any burst still running.
    task automatic run_out_burst();
        drain();
        while (burst_busy) begin
            while (burst_busy) send_item(OP_TICK, 24'($urandom), 8'($urandom));
            drain();
        end
    endtask

    task automatic random_item(input int max_reps);
        int          r;
        logic [23:0] code_v;
        logic [7:0]  reps_v;
        r = $urandom_range(99);
        code_v = 24'($urandom);
        reps_v = 8'($urandom);
        if (r < 85) begin
            send_item(OP_TICK, code_v, reps_v);
        end else if (r < 95) begin
            send_item(OP_START, code_v, 8'($urandom_range(max_reps, 1)));
        end else if (prev_op == OP_START && burst_busy) begin
            // busy for sure here, so any repeat count is dropped
            send_item(OP_START, code_v, reps_v);
        end else begin
            send_item(OP_START, code_v, 8'($urandom_range(max_reps, 0)));
        end
    endtask

    initial begin
        int cpp_val;
        int cpp_eff;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        set_idle(IDLE_SENDER_LIGHT);
        apb_write(REG_CPP, 32'd1);
        apb_write(REG_CARRIER, 32'd1);

        send_item(OP_TICK, 24'hFFFFFF, 8'hFF);
        send_item(OP_START, 24'hFFFFFF, 8'd0);
        send_item(OP_TICK, 24'h000000, 8'h00);
        send_item(OP_START, 24'h800001, 8'd2);
        send_item(OP_START, 24'h000000, 8'd255);
        run_out_burst();

        for (int p = 0; p < PHASES; p++) begin
            set_idle(idle_mode_t'(p % 3));
            cpp_val = (p == PHASES - 1) ? $urandom_range(5, 1) : cpp_plan[p];
            cpp_eff = (cpp_val == 0) ? 1 : (cpp_val > 16) ? 16 : cpp_val;
            apb_write(REG_CPP, 32'(cpp_val));
            apb_write(REG_CARRIER, {31'd0, carrier_plan[p]});
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                random_item((cpp_eff <= 2) ? 3 : 1);
            end
            drain();
        end

        set_idle(IDLE_SENDER_LIGHT);
        apb_write(REG_CPP, 32'd1);
        run_out_burst();

        // long burst: two frames complete with the frame counter near its top
        send_item(OP_START, {1'b1, 23'($urandom)}, 8'd255);
        repeat (280) send_item(OP_TICK, 24'($urandom), 8'($urandom));
        s_tvalid <= 1'b0;

        do @(posedge aclk); while (chips_pending != 0);
        repeat (10) @(posedge aclk);
        if (mismatches == 0 && chips_pending == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
